### rtl/core/cau_pkg.sv
package cau_pkg;

	// Default part format: signed Q8.8.
	localparam int PART_WIDTH_DEF    = 16;
	localparam int FRACTION_BITS_DEF = 8;

	// Operation codes carried in the kind field of a request.
	localparam logic [1:0] KIND_ADD = 2'd0;
	localparam logic [1:0] KIND_SUB = 2'd1;
	localparam logic [1:0] KIND_MUL = 2'd2;
	localparam logic [1:0] KIND_DIV = 2'd3;

	// Control bits that travel with each request down the divider chain.
	typedef struct packed {
		logic div;     // request is a divide
		logic dz;      // divisor magnitude is zero
		logic run_re;  // real lane is being divided
		logic run_im;  // imaginary lane is being divided
		logic neg_re;  // sign of the real result
		logic neg_im;  // sign of the imaginary result
	} cau_ctrl_t;

endpackage

### rtl/core/cau_req_if.sv
interface cau_req_if #(
	parameter int PART_WIDTH = cau_pkg::PART_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic [1:0]                   kind;
	logic signed [PART_WIDTH-1:0] a_real;
	logic signed [PART_WIDTH-1:0] a_imag;
	logic signed [PART_WIDTH-1:0] b_real;
	logic signed [PART_WIDTH-1:0] b_imag;

	modport source (output valid, kind, a_real, a_imag, b_real, b_imag, input ready);
	modport sink (input valid, kind, a_real, a_imag, b_real, b_imag, output ready);
endinterface

### rtl/core/cau_rsp_if.sv
interface cau_rsp_if #(
	parameter int PART_WIDTH = cau_pkg::PART_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [PART_WIDTH-1:0] result_real;
	logic signed [PART_WIDTH-1:0] result_imag;
	logic                         overflow;
	logic                         divide_by_zero;

	modport source (output valid, result_real, result_imag, overflow, divide_by_zero,
		input ready);
	modport sink (input valid, result_real, result_imag, overflow, divide_by_zero,
		output ready);
endinterface

### rtl/core/cau_front.sv
module cau_front #(
	parameter int PART_WIDTH    = cau_pkg::PART_WIDTH_DEF,
	parameter int FRACTION_BITS = cau_pkg::FRACTION_BITS_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	cau_req_if.sink                                      request,
	output logic                                         out_valid,
	input  logic                                         out_ready,
	output cau_pkg::cau_ctrl_t                           out_ctrl,
	output logic [2*PART_WIDTH-1:0]                      out_den,
	output logic [2*PART_WIDTH+FRACTION_BITS-1:0]        out_q_re,
	output logic [2*PART_WIDTH+FRACTION_BITS-1:0]        out_q_im
);
	import cau_pkg::*;

	localparam int PW = PART_WIDTH;
	localparam int FB = FRACTION_BITS;
	localparam int QW = 2*PW + FB;
	localparam logic [2*PW:0] HALF = (FB > 0) ? ((2*PW+1)'(1) << (FB - 1)) : '0;

	typedef struct packed {
		logic          neg;
		logic          run;
		logic [QW-1:0] q;
	} lane_t;

	// Stage 1 registers: sums and the six partial products.
	logic                     v_s1;
	logic [1:0]               kind_s1;
	logic signed [PW:0]       sre_s1, sim_s1;
	logic signed [2*PW-1:0]   prr_s1, pii_s1, pri_s1, pir_s1, pbr_s1, pbi_s1;

	// Stage 2 registers.
	logic                     v_s2;
	cau_ctrl_t                ctrl_s2;
	logic [2*PW-1:0]          den_s2;
	logic [QW-1:0]            qre_s2, qim_s2;

	logic                     rdy1, rdy2;
	logic signed [2*PW-1:0]   ar_x, ai_x, br_x, bi_x;
	logic signed [PW:0]       sre_c, sim_c;

	logic signed [2*PW:0]     xmr, xmi, xdr, xdi;
	logic [2*PW-1:0]          den_c;
	logic                     dz_c;
	lane_t                    lre, lim;

	// Prepare one lane: pick the value, take its magnitude, round or set up the dividend.
	function automatic lane_t prep(input logic [1:0] k, input logic signed [PW:0] s,
		input logic signed [2*PW:0] xm, input logic signed [2*PW:0] xd,
		input logic [2*PW-1:0] d, input logic dz);
		lane_t                l;
		logic signed [2*PW:0] v;
		logic [2*PW:0]        mag;
		logic [2*PW:0]        mr;
		logic [3*PW-1:0]      lim3;
		logic                 sat;
		if (k == KIND_ADD || k == KIND_SUB) begin
			v = (2*PW+1)'(s);
		end else if (k == KIND_MUL) begin
			v = xm;
		end else begin
			v = xd;
		end
		l.neg = v[2*PW];
		mag   = l.neg ? (2*PW+1)'(-v) : (2*PW+1)'(v);
		mr    = (mag + HALF) >> FB;
		lim3  = (3*PW)'(d) << PW;
		sat   = (3*PW)'(mag) >= lim3;
		l.run = 1'b0;
		if (k == KIND_DIV) begin
			l.run = !dz && !sat;
			l.q   = QW'(mag[2*PW-1:0]) << FB;
		end else if (k == KIND_MUL) begin
			l.q = QW'(mr[2*PW-1:0]);
		end else begin
			l.q = QW'(mag[2*PW-1:0]);
		end
		return l;
	endfunction

	assign rdy2          = !v_s2 || out_ready;
	assign rdy1          = !v_s1 || rdy2;
	assign request.ready = rdy1;

	// Stage 1 arithmetic: add or subtract, and the products of the parts.
	assign ar_x  = (2*PW)'(request.a_real);
	assign ai_x  = (2*PW)'(request.a_imag);
	assign br_x  = (2*PW)'(request.b_real);
	assign bi_x  = (2*PW)'(request.b_imag);
	assign sre_c = (request.kind == KIND_SUB) ?
		((PW+1)'(request.a_real) - (PW+1)'(request.b_real)) :
		((PW+1)'(request.a_real) + (PW+1)'(request.b_real));
	assign sim_c = (request.kind == KIND_SUB) ?
		((PW+1)'(request.a_imag) - (PW+1)'(request.b_imag)) :
		((PW+1)'(request.a_imag) + (PW+1)'(request.b_imag));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= request.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && request.valid) begin
			kind_s1 <= request.kind;
			sre_s1  <= sre_c;
			sim_s1  <= sim_c;
			prr_s1  <= ar_x * br_x;
			pii_s1  <= ai_x * bi_x;
			pri_s1  <= ar_x * bi_x;
			pir_s1  <= ai_x * br_x;
			pbr_s1  <= br_x * br_x;
			pbi_s1  <= bi_x * bi_x;
		end
	end

	// Stage 2 arithmetic: sums of products, divisor magnitude, lane setup.
	assign xmr   = (2*PW+1)'(prr_s1) - (2*PW+1)'(pii_s1);
	assign xmi   = (2*PW+1)'(pri_s1) + (2*PW+1)'(pir_s1);
	assign xdr   = (2*PW+1)'(prr_s1) + (2*PW+1)'(pii_s1);
	assign xdi   = (2*PW+1)'(pir_s1) - (2*PW+1)'(pri_s1);
	assign den_c = (2*PW)'(unsigned'(pbr_s1)) + (2*PW)'(unsigned'(pbi_s1));
	assign dz_c  = (den_c == '0);
	assign lre   = prep(kind_s1, sre_s1, xmr, xdr, den_c, dz_c);
	assign lim   = prep(kind_s1, sim_s1, xmi, xdi, den_c, dz_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			ctrl_s2.div    <= (kind_s1 == KIND_DIV);
			ctrl_s2.dz     <= (kind_s1 == KIND_DIV) && dz_c;
			ctrl_s2.run_re <= lre.run;
			ctrl_s2.run_im <= lim.run;
			ctrl_s2.neg_re <= lre.neg;
			ctrl_s2.neg_im <= lim.neg;
			den_s2         <= den_c;
			qre_s2         <= lre.q;
			qim_s2         <= lim.q;
		end
	end

	assign out_valid = v_s2;
	assign out_ctrl  = ctrl_s2;
	assign out_den   = den_s2;
	assign out_q_re  = qre_s2;
	assign out_q_im  = qim_s2;

endmodule

### rtl/core/cau_cell.sv
module cau_cell #(
	parameter int PART_WIDTH    = cau_pkg::PART_WIDTH_DEF,
	parameter int FRACTION_BITS = cau_pkg::FRACTION_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  cau_pkg::cau_ctrl_t                    in_ctrl,
	input  logic [2*PART_WIDTH-1:0]               in_den,
	input  logic [2*PART_WIDTH-1:0]               in_a_re,
	input  logic [2*PART_WIDTH-1:0]               in_a_im,
	input  logic [2*PART_WIDTH+FRACTION_BITS-1:0] in_q_re,
	input  logic [2*PART_WIDTH+FRACTION_BITS-1:0] in_q_im,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output cau_pkg::cau_ctrl_t                    out_ctrl,
	output logic [2*PART_WIDTH-1:0]               out_den,
	output logic [2*PART_WIDTH-1:0]               out_a_re,
	output logic [2*PART_WIDTH-1:0]               out_a_im,
	output logic [2*PART_WIDTH+FRACTION_BITS-1:0] out_q_re,
	output logic [2*PART_WIDTH+FRACTION_BITS-1:0] out_q_im
);
	import cau_pkg::*;

	localparam int PW = PART_WIDTH;
	localparam int QW = 2*PW + FRACTION_BITS;

	logic            valid_q;
	cau_ctrl_t       ctrl_q;
	logic [2*PW-1:0] den_q, are_q, aim_q;
	logic [QW-1:0]   qre_q, qim_q;
	logic [2*PW-1:0] are_n, aim_n;
	logic [QW-1:0]   qre_n, qim_n;

	// One restoring division step: shift remainder and dividend, try to subtract.
	function automatic logic [2*PW+QW-1:0] step(input logic run, input logic [2*PW-1:0] a,
		input logic [QW-1:0] q, input logic [2*PW-1:0] d);
		logic [2*PW:0]   ash;
		logic [2*PW:0]   diff;
		logic            ge;
		logic [2*PW-1:0] an;
		logic [QW-1:0]   qn;
		ash  = {a, q[QW-1]};
		diff = ash - {1'b0, d};
		ge   = ash >= {1'b0, d};
		an   = ge ? diff[2*PW-1:0] : ash[2*PW-1:0];
		qn   = {q[QW-2:0], ge};
		return run ? {an, qn} : {a, q};
	endfunction

	assign {are_n, qre_n} = step(in_ctrl.run_re, in_a_re, in_q_re, in_den);
	assign {aim_n, qim_n} = step(in_ctrl.run_im, in_a_im, in_q_im, in_den);
	assign in_ready       = !valid_q || out_ready;

	// Handshake state of this cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// Payload moves on with the step applied.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ctrl_q <= in_ctrl;
			den_q  <= in_den;
			are_q  <= are_n;
			aim_q  <= aim_n;
			qre_q  <= qre_n;
			qim_q  <= qim_n;
		end
	end

	assign out_valid = valid_q;
	assign out_ctrl  = ctrl_q;
	assign out_den   = den_q;
	assign out_a_re  = are_q;
	assign out_a_im  = aim_q;
	assign out_q_re  = qre_q;
	assign out_q_im  = qim_q;

endmodule

### rtl/core/cau_back.sv
module cau_back #(
	parameter int PART_WIDTH    = cau_pkg::PART_WIDTH_DEF,
	parameter int FRACTION_BITS = cau_pkg::FRACTION_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  cau_pkg::cau_ctrl_t                    in_ctrl,
	input  logic [2*PART_WIDTH-1:0]               in_den,
	input  logic [2*PART_WIDTH-1:0]               in_a_re,
	input  logic [2*PART_WIDTH-1:0]               in_a_im,
	input  logic [2*PART_WIDTH+FRACTION_BITS-1:0] in_q_re,
	input  logic [2*PART_WIDTH+FRACTION_BITS-1:0] in_q_im,
	cau_rsp_if.source                             result
);
	import cau_pkg::*;

	localparam int PW = PART_WIDTH;
	localparam int QW = 2*PW + FRACTION_BITS;
	localparam logic [QW:0] NLIM = (QW+1)'(1) << (PW - 1);
	localparam logic [QW:0] PLIM = NLIM - (QW+1)'(1);
	localparam logic [QW:0] OVER = (QW+1)'(1) << PW;

	logic          valid_q;
	logic [PW-1:0] re_q, im_q;
	logic          ov_q, dz_q;
	logic [PW:0]   re_c, im_c;

	// Final rounding of a quotient, then clamp to the part range; returns {ov, value}.
	function automatic logic [PW:0] finish(input logic dz, input logic div, input logic run,
		input logic neg, input logic [2*PW-1:0] a, input logic [QW-1:0] q,
		input logic [2*PW-1:0] d);
		logic [QW:0] m;
		logic        ov;
		if (dz) begin
			m = '0;
		end else if (div && !run) begin
			m = OVER;
		end else if (run) begin
			m = (QW+1)'(q) + (QW+1)'({a, 1'b0} >= {1'b0, d});
		end else begin
			m = (QW+1)'(q);
		end
		ov = 1'b0;
		if (!neg && m > PLIM) begin
			m  = PLIM;
			ov = 1'b1;
		end else if (neg && m > NLIM) begin
			m  = NLIM;
			ov = 1'b1;
		end
		return neg ? {ov, PW'(-m)} : {ov, PW'(m)};
	endfunction

	assign re_c = finish(in_ctrl.dz, in_ctrl.div, in_ctrl.run_re, in_ctrl.neg_re,
		in_a_re, in_q_re, in_den);
	assign im_c = finish(in_ctrl.dz, in_ctrl.div, in_ctrl.run_im, in_ctrl.neg_im,
		in_a_im, in_q_im, in_den);
	assign in_ready = !valid_q || result.ready;

	// Output register holds the result until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			re_q <= re_c[PW-1:0];
			im_q <= im_c[PW-1:0];
			ov_q <= re_c[PW] | im_c[PW];
			dz_q <= in_ctrl.dz;
		end
	end

	assign result.valid          = valid_q;
	assign result.result_real    = re_q;
	assign result.result_imag    = im_q;
	assign result.overflow       = ov_q;
	assign result.divide_by_zero = dz_q;

endmodule

### rtl/core/complex_arithmetic_unit.sv
// Fixed-point complex ALU: add, subtract, multiply and divide of two complex
// operands, parts signed with FRACTION_BITS fraction bits (default Q8.8).
// The request channel carries kind and the parts of A and B; the result
// channel returns both result parts plus overflow and divide_by_zero flags.
// Both channels use valid/ready; a request moves when both are high.
// One request is accepted per cycle when the result side keeps up.
// A request passes through the product and sum stages, then the restoring
// divider chain (one quotient bit per cell), then rounding and clamping
// into the output register. Every request runs through the whole chain.
// Results that do not fit the part range saturate and set overflow; a
// divide by zero returns zero with divide_by_zero set.
// Reset empties every stage. When the receiver stalls, the output register
// holds its result and the stages behind it close up their bubbles, then
// hold; ready on the request side drops only when every stage is full.
module complex_arithmetic_unit #(
	parameter int PART_WIDTH    = cau_pkg::PART_WIDTH_DEF,
	parameter int FRACTION_BITS = cau_pkg::FRACTION_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	cau_req_if.sink    request,
	cau_rsp_if.source  result
);
	import cau_pkg::*;

	localparam int PW = PART_WIDTH;
	localparam int QW = 2*PW + FRACTION_BITS;
	localparam int NC = QW;

	logic            valid_c [NC+1];
	logic            ready_c [NC+1];
	cau_ctrl_t       ctrl_c  [NC+1];
	logic [2*PW-1:0] den_c   [NC+1];
	logic [2*PW-1:0] are_c   [NC+1];
	logic [2*PW-1:0] aim_c   [NC+1];
	logic [QW-1:0]   qre_c   [NC+1];
	logic [QW-1:0]   qim_c   [NC+1];

	// Products, sums and dividend setup.
	cau_front #(
		.PART_WIDTH   (PART_WIDTH),
		.FRACTION_BITS(FRACTION_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request),
		.out_valid(valid_c[0]),
		.out_ready(ready_c[0]),
		.out_ctrl (ctrl_c[0]),
		.out_den  (den_c[0]),
		.out_q_re (qre_c[0]),
		.out_q_im (qim_c[0])
	);

	// The partial remainder starts at zero.
	assign are_c[0] = '0;
	assign aim_c[0] = '0;

	// Divider chain, one quotient bit per cell.
	for (genvar i = 0; i < NC; i++) begin : g_cell
		cau_cell #(
			.PART_WIDTH   (PART_WIDTH),
			.FRACTION_BITS(FRACTION_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (valid_c[i]),
			.in_ready (ready_c[i]),
			.in_ctrl  (ctrl_c[i]),
			.in_den   (den_c[i]),
			.in_a_re  (are_c[i]),
			.in_a_im  (aim_c[i]),
			.in_q_re  (qre_c[i]),
			.in_q_im  (qim_c[i]),
			.out_valid(valid_c[i+1]),
			.out_ready(ready_c[i+1]),
			.out_ctrl (ctrl_c[i+1]),
			.out_den  (den_c[i+1]),
			.out_a_re (are_c[i+1]),
			.out_a_im (aim_c[i+1]),
			.out_q_re (qre_c[i+1]),
			.out_q_im (qim_c[i+1])
		);
	end

	// Rounding, saturation and the output register.
	cau_back #(
		.PART_WIDTH   (PART_WIDTH),
		.FRACTION_BITS(FRACTION_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(valid_c[NC]),
		.in_ready(ready_c[NC]),
		.in_ctrl (ctrl_c[NC]),
		.in_den  (den_c[NC]),
		.in_a_re (are_c[NC]),
		.in_a_im (aim_c[NC]),
		.in_q_re (qre_c[NC]),
		.in_q_im (qim_c[NC]),
		.result  (result)
	);

endmodule

### verif/complex_arithmetic_unit_tb.sv
`timescale 1ns / 100ps

module complex_arithmetic_unit_tb;
	import cau_pkg::*;

	localparam int PW = PART_WIDTH_DEF;
	localparam int FB = FRACTION_BITS_DEF;
	localparam longint PART_MAX = (64'sd1 <<< (PW - 1)) - 1;
	localparam longint PART_MIN = -(64'sd1 <<< (PW - 1));
	localparam logic [PW-1:0] PMAX_BITS = PW'(PART_MAX);
	localparam logic [PW-1:0] PMIN_BITS = PW'(PART_MIN);

	typedef struct {
		logic signed [PW-1:0] re;
		logic signed [PW-1:0] im;
		logic                 ov;
		logic                 dz;
	} cau_result_t;

	// Scoreboard: works out the complex result of each accepted request.
	class cau_scoreboard;
		cau_result_t pending[$];
		int          mismatches;

		function longint clamp(longint v, inout logic ov);
			if (v > PART_MAX) begin
				ov = 1'b1;
				return PART_MAX;
			end
			if (v < PART_MIN) begin
				ov = 1'b1;
				return PART_MIN;
			end
			return v;
		endfunction

		// Drops FB fraction bits, rounding to nearest with ties away from zero.
		function longint round_shift(longint v);
			longint mag;
			mag = ((v < 0 ? -v : v) + (64'sd1 <<< (FB - 1))) >>> FB;
			return v < 0 ? -mag : mag;
		endfunction

		// Signed quotient with FB fraction bits, rounded the same way.
		function longint quotient(longint num, longint den);
			longint mag, q, r;
			mag = num < 0 ? -num : num;
			if (mag / den >= (64'sd1 <<< PW)) begin
				q = 64'sd1 <<< PW;
			end else begin
				q = (mag <<< FB) / den;
				r = (mag <<< FB) % den;
				if (2 * r >= den)
					q = q + 1;
			end
			return num < 0 ? -q : q;
		endfunction

		function void note_request(logic [1:0] kind, longint ar, longint ai,
			longint br, longint bi);
			cau_result_t exp_res;
			longint re, im, den;
			logic ov;
			ov = 1'b0;
			exp_res.dz = 1'b0;
			case (kind)
				KIND_ADD: begin
					re = ar + br;
					im = ai + bi;
				end
				KIND_SUB: begin
					re = ar - br;
					im = ai - bi;
				end
				KIND_MUL: begin
					re = round_shift(ar * br - ai * bi);
					im = round_shift(ar * bi + ai * br);
				end
				default: begin
					den = br * br + bi * bi;
					if (den == 0) begin
						exp_res.dz = 1'b1;
						re = 0;
						im = 0;
					end else begin
						re = quotient(ar * br + ai * bi, den);
						im = quotient(ai * br - ar * bi, den);
					end
				end
			endcase
			exp_res.re = PW'(clamp(re, ov));
			exp_res.im = PW'(clamp(im, ov));
			exp_res.ov = ov;
			pending.push_back(exp_res);
		endfunction

		function void check_result(cau_result_t got);
			cau_result_t exp_res;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result re=%0d im=%0d ov=%0b dz=%0b",
						got.re, got.im, got.ov, got.dz);
				return;
			end
			exp_res = pending.pop_front();
			if (got.re !== exp_res.re || got.im !== exp_res.im ||
				got.ov !== exp_res.ov || got.dz !== exp_res.dz) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch: expected re=%0d im=%0d ov=%0b dz=%0b, ",
						"got re=%0d im=%0d ov=%0b dz=%0b"},
						exp_res.re, exp_res.im, exp_res.ov, exp_res.dz,
						got.re, got.im, got.ov, got.dz);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;

	cau_req_if #(.PART_WIDTH(PW)) req_if();
	cau_rsp_if #(.PART_WIDTH(PW)) rsp_if();
	cau_scoreboard sb;

	complex_arithmetic_unit #(.PART_WIDTH(PW), .FRACTION_BITS(FB)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.request(req_if.sink),
		.result (rsp_if.source)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Overall time limit.
	initial begin
		#5ms;
		$display("complex_arithmetic_unit verification failed");
		$finish;
	end

	// Sends one request, with a random idle gap first, and waits for acceptance.
	task automatic send_request(logic [1:0] kind, logic [PW-1:0] ar, logic [PW-1:0] ai,
		logic [PW-1:0] br, logic [PW-1:0] bi);
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid  <= 1'b1;
		req_if.kind   <= kind;
		req_if.a_real <= ar;
		req_if.a_imag <= ai;
		req_if.b_real <= br;
		req_if.b_imag <= bi;
		@(negedge clk);
		while (!req_if.ready)
			@(negedge clk);
		sb.note_request(kind, $signed(ar), $signed(ai), $signed(br), $signed(bi));
		@(posedge clk);
	endtask

	task automatic idle_sender();
		req_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Random operand, weighted toward extremes and small magnitudes.
	function automatic logic [PW-1:0] rand_part();
		case ($urandom_range(7))
			0: return PMAX_BITS;
			1: return PMIN_BITS;
			2: return PW'($urandom_range(7) - 3);
			3: return PW'($signed($urandom_range(2047)) - 1024);
			default: return PW'($urandom);
		endcase
	endfunction

	task automatic send_random(int count);
		logic [PW-1:0] br, bi;
		repeat (count) begin
			br = rand_part();
			bi = rand_part();
			if ($urandom_range(15) == 0) begin
				br = '0;
				bi = '0;
			end
			send_request(2'($urandom_range(3)), rand_part(), rand_part(), br, bi);
		end
	endtask

	// Receiver: random backpressure; results checked at the accepting edge.
	initial begin
		rsp_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		cau_result_t got;
		forever begin
			@(negedge clk);
			if (arst_n && rsp_if.valid && rsp_if.ready) begin
				got.re = rsp_if.result_real;
				got.im = rsp_if.result_imag;
				got.ov = rsp_if.overflow;
				got.dz = rsp_if.divide_by_zero;
				@(posedge clk);
				sb.check_result(got);
			end
		end
	end

	// Main sequence.
	initial begin
		int wait_cycles;
		sb = new();
		send_idle_pct = 15;
		recv_idle_pct = 74;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.kind = KIND_ADD;
		req_if.a_real = '0;
		req_if.a_imag = '0;
		req_if.b_real = '0;
		req_if.b_imag = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests: extremes, every operation, rounding ties, zero divisor.
		send_request(KIND_ADD, PMAX_BITS, PMIN_BITS, PMAX_BITS, PMIN_BITS);
		send_request(KIND_ADD, PMAX_BITS, PMIN_BITS, PMIN_BITS, PMAX_BITS);
		send_request(KIND_ADD, 16'h0001, 16'hffff, 16'h7000, 16'h9000);
		send_request(KIND_SUB, PMAX_BITS, PMIN_BITS, PMIN_BITS, PMAX_BITS);
		send_request(KIND_SUB, PMIN_BITS, PMAX_BITS, PMIN_BITS, PMAX_BITS);
		send_request(KIND_SUB, 16'h0000, 16'h0000, PMIN_BITS, 16'h0001);
		send_request(KIND_MUL, PMAX_BITS, PMAX_BITS, PMAX_BITS, PMAX_BITS);
		send_request(KIND_MUL, PMIN_BITS, PMIN_BITS, PMIN_BITS, PMIN_BITS);
		send_request(KIND_MUL, PMIN_BITS, 16'h0000, PMIN_BITS, 16'h0000);
		send_request(KIND_MUL, 16'h0080, 16'h0000, 16'h0001, 16'h0000);
		send_request(KIND_MUL, 16'hff80, 16'h0000, 16'h0001, 16'h0000);
		send_request(KIND_MUL, 16'h0100, 16'h0100, 16'h0100, 16'hff00);
		send_request(KIND_DIV, PMAX_BITS, PMIN_BITS, 16'h0000, 16'h0000);
		send_request(KIND_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_request(KIND_DIV, PMAX_BITS, PMAX_BITS, 16'h0001, 16'h0000);
		send_request(KIND_DIV, PMIN_BITS, PMIN_BITS, 16'h0000, 16'h0001);
		send_request(KIND_DIV, 16'h0100, 16'h0000, 16'h0300, 16'h0000);
		send_request(KIND_DIV, 16'h0080, 16'h0000, 16'h0100, 16'h0000);
		send_request(KIND_DIV, PMIN_BITS, PMIN_BITS, PMIN_BITS, PMIN_BITS);
		send_request(KIND_DIV, PMAX_BITS, PMIN_BITS, PMAX_BITS, PMAX_BITS);
		send_request(KIND_DIV, 16'h0100, 16'h0100, 16'h0000, 16'h0100);

		send_random(250);

		// Hold off until the pipeline has drained completely.
		idle_sender();
		while (sb.pending.size() != 0)
			@(posedge clk);

		send_idle_pct = 74;
		recv_idle_pct = 15;
		send_random(270);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random(280);
		idle_sender();

		wait_cycles = 0;
		while (sb.pending.size() != 0 && wait_cycles < 100000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (2 * PW + FB + 20) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("complex_arithmetic_unit verification clean");
		else
			$display("complex_arithmetic_unit verification failed");
		$finish;
	end

endmodule
